// ===== src/sobel_pkg.sv =====
`default_nettype none

package sobel_pkg;

    // Field widths of the stream items.
    localparam int PIXEL_W  = 8;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 11;
    localparam int OUT_W    = 32;
    localparam int OUT_PAD  = OUT_W - PIXEL_W - ROW_W - COL_W;

    // Configuration register widths and port format.
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 13;
    localparam int THR_W      = 11;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Arithmetic widths: weighted sums, gradients, squares and limits.
    localparam int WSUM_W = 10;
    localparam int GRAD_W = 11;
    localparam int SQ_W   = 20;
    localparam int MAG_W  = 21;
    localparam int LIM_W  = 24;

    // Register reset values.
    localparam logic [IMG_W_W-1:0] RST_IMG_W = 12'd640;
    localparam logic [IMG_H_W-1:0] RST_IMG_H = 13'd480;
    localparam logic [LIM_W-1:0]   RST_LIM   = 24'd10201;

    // Result codes.
    localparam logic [PIXEL_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIXEL_W-1:0] EDGE_OFF = 8'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } t_cfg_idx;

    // Gradient item passed from the window front end to the magnitude stage.
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic                     frame_end;
    } t_grad;

    // Result item.
    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [PIXEL_W-1:0] edge_value;
        logic               frame_end;
    } t_result;

    // Weighted 1-2-1 sum of three pixels.
    function automatic logic [WSUM_W-1:0] wsum(
        input logic [PIXEL_W-1:0] a,
        input logic [PIXEL_W-1:0] b,
        input logic [PIXEL_W-1:0] c
    );
        return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    // Signed difference of two weighted sums.
    function automatic logic signed [GRAD_W-1:0] wdiff(
        input logic [WSUM_W-1:0] p,
        input logic [WSUM_W-1:0] n
    );
        return $signed({1'b0, p}) - $signed({1'b0, n});
    endfunction

endpackage

`default_nettype wire

// ===== src/sobel_ram.sv =====
`default_nettype none

module sobel_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/sobel_window.sv =====
`default_nettype none

module sobel_window #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [$clog2(MAX_WIDTH):0]      i_width,
    input  wire logic [$clog2(MAX_HEIGHT):0]     i_height,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [sobel_pkg::PIXEL_W-1:0]   i_pixel,
    input  wire logic                            i_frame_start,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output sobel_pkg::t_grad                     o_grad
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CNW = CW + 1;
    localparam int RNW = RW + 1;
    localparam int PW  = sobel_pkg::PIXEL_W;

    logic [CW-1:0] r_col, n_col, cur_c;
    logic [RW-1:0] r_row, n_row, cur_r;
    logic [CNW-1:0] c_inc;
    logic [RNW-1:0] r_inc;
    logic acc, s1_adv, out_free;

    logic r_s1_valid;
    logic [PW-1:0] r_s1_px;
    logic [CW-1:0] r_s1_idx;
    logic r_s1_emit, r_s1_fend, r_s1_fwd;
    logic [sobel_pkg::ROW_W-1:0] r_s1_row;
    logic [sobel_pkg::COL_W-1:0] r_s1_col;
    logic [PW-1:0] r_s1_fwd_top, r_s1_fwd_mid;
    logic [PW-1:0] s1_top, s1_mid;
    logic [2*PW-1:0] ram_rdata;

    logic [PW-1:0] r_win [6];
    logic r_g_valid;
    sobel_pkg::t_grad r_g, n_g;

    // Stage handshake: the gradient register frees stage one, stage one frees the input.
    assign out_free = !r_g_valid || i_ready;
    assign s1_adv   = r_s1_valid && (!r_s1_emit || out_free);
    assign o_ready  = !r_s1_valid || s1_adv;
    assign acc      = i_valid && o_ready;

    // Position of the arriving pixel; frame start forces the origin.
    assign cur_c = i_frame_start ? '0 : r_col;
    assign cur_r = i_frame_start ? '0 : r_row;
    assign c_inc = {1'b0, cur_c} + CNW'(1);
    assign r_inc = {1'b0, cur_r} + RNW'(1);

    // Column wraps at the width, row wraps at the height.
    always_comb begin
        n_col = c_inc[CW-1:0];
        n_row = cur_r;
        if (c_inc >= i_width) begin
            n_col = '0;
            n_row = (r_inc >= i_height) ? '0 : r_inc[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line stores: upper row in the high byte, middle row in the low byte.
    sobel_ram #(
        .DATA_W (2 * PW),
        .DEPTH  (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_idx),
        .i_wdata ({s1_mid, r_s1_px}),
        .i_re    (acc),
        .i_raddr (cur_c),
        .o_rdata (ram_rdata)
    );

    // The column read this cycle may be the one stage one writes now; take its data.
    assign s1_top = r_s1_fwd ? r_s1_fwd_top : ram_rdata[2*PW-1:PW];
    assign s1_mid = r_s1_fwd ? r_s1_fwd_mid : ram_rdata[PW-1:0];

    // Stage one holds the pixel while its line-store read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_px      <= i_pixel;
            r_s1_idx     <= cur_c;
            r_s1_emit    <= (cur_r >= RW'(2)) && (cur_c >= CW'(2));
            r_s1_fend    <= ({1'b0, cur_r} == (i_height - RNW'(1)))
                         && ({1'b0, cur_c} == (i_width - CNW'(1)));
            r_s1_row     <= sobel_pkg::ROW_W'(cur_r - RW'(1));
            r_s1_col     <= sobel_pkg::COL_W'(cur_c - CW'(1));
            r_s1_fwd     <= r_s1_valid && (r_s1_idx == cur_c);
            r_s1_fwd_top <= s1_mid;
            r_s1_fwd_mid <= r_s1_px;
        end
    end

    // Window shifts by one column per item: 0..2 oldest column, 3..5 newer column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= s1_top;
            r_win[4] <= s1_mid;
            r_win[5] <= r_s1_px;
        end
    end

    // Sobel gradients: rows top minus bottom, columns left minus right.
    always_comb begin
        n_g.gx = sobel_pkg::wdiff(sobel_pkg::wsum(r_win[0], r_win[3], s1_top),
                                  sobel_pkg::wsum(r_win[2], r_win[5], r_s1_px));
        n_g.gy = sobel_pkg::wdiff(sobel_pkg::wsum(r_win[0], r_win[1], r_win[2]),
                                  sobel_pkg::wsum(s1_top, s1_mid, r_s1_px));
        n_g.row       = r_s1_row;
        n_g.col       = r_s1_col;
        n_g.frame_end = r_s1_fend;
    end

    // Gradient register; border pixels leave no item here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (s1_adv && r_s1_emit) begin
            r_g_valid <= 1'b1;
        end else if (i_ready) begin
            r_g_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_g <= n_g;
        end
    end

    assign o_valid = r_g_valid;
    assign o_grad  = r_g;

endmodule

`default_nettype wire

// ===== src/sobel_mag.sv =====
`default_nettype none

module sobel_mag (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [sobel_pkg::LIM_W-1:0]    i_limit,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire sobel_pkg::t_grad               i_grad,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output sobel_pkg::t_result                  o_result
);

    localparam int GW = sobel_pkg::GRAD_W;

    logic r_sq_valid, r_o_valid, o_free, sq_adv;
    logic [sobel_pkg::SQ_W-1:0] r_sqx, r_sqy;
    logic [2*GW-1:0] prod_x, prod_y;
    logic [sobel_pkg::ROW_W-1:0] r_sq_row;
    logic [sobel_pkg::COL_W-1:0] r_sq_col;
    logic r_sq_fend;
    logic [sobel_pkg::MAG_W-1:0] mag2;
    sobel_pkg::t_result r_o;

    assign o_free  = !r_o_valid || i_ready;
    assign sq_adv  = r_sq_valid && o_free;
    assign o_ready = !r_sq_valid || o_free;

    // Squares of both gradients; each fits in 20 bits.
    assign prod_x = (2*GW)'($signed(i_grad.gx) * $signed(i_grad.gx));
    assign prod_y = (2*GW)'($signed(i_grad.gy) * $signed(i_grad.gy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_sq_valid <= 1'b1;
        end else if (sq_adv) begin
            r_sq_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_sqx     <= prod_x[sobel_pkg::SQ_W-1:0];
            r_sqy     <= prod_y[sobel_pkg::SQ_W-1:0];
            r_sq_row  <= i_grad.row;
            r_sq_col  <= i_grad.col;
            r_sq_fend <= i_grad.frame_end;
        end
    end

    // Magnitude test: sum of squares against the squared threshold plus one.
    assign mag2 = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (sq_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sq_adv) begin
            r_o.edge_value <= (sobel_pkg::LIM_W'(mag2) >= i_limit) ?
                              sobel_pkg::EDGE_ON : sobel_pkg::EDGE_OFF;
            r_o.row        <= r_sq_row;
            r_o.col        <= r_sq_col;
            r_o.frame_end  <= r_sq_fend;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_o;

endmodule

`default_nettype wire

// ===== src/sobel_edge_threshold.sv =====
`default_nettype none

// Sobel edge detector with a magnitude threshold. Pixels enter in raster order
// on s_axis (tuser marks the first pixel of a frame); one result per interior
// pixel leaves on m_axis, carrying 255 for an edge or 0, the pixel's row and
// column, and tlast on the last interior pixel of the frame. Border pixels give
// no result. The block takes one pixel every clock unless the output stalls; each
// pixel passes the stage-one register with the line-store read, then the gradient
// register, the squares register and the compare register. The pace is set by
// the line-store RAM (MAX_WIDTH words of two pixels), read and written once per
// pixel; it needs no clearing after reset. The user must write geometry and
// threshold on the cfg port only while no frame is in flight; the block does not
// enforce it. Width and height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
module sobel_edge_threshold #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write channel.
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sobel_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sobel_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Pixel input.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [7:0] pixel
    input  wire logic                                s_axis_tuser,  // [0] frame_start
    // Result output.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [7:0] edge_value, [19:8] out_row, [30:20] out_col, [31] zero
    output logic [sobel_pkg::OUT_W-1:0]              m_axis_tdata,
    output logic                                     m_axis_tlast   // frame_end
);

    localparam int CNW = $clog2(MAX_WIDTH) + 1;
    localparam int RNW = $clog2(MAX_HEIGHT) + 1;

    logic [sobel_pkg::IMG_W_W-1:0] r_img_w;
    logic [sobel_pkg::IMG_H_W-1:0] r_img_h;
    logic [sobel_pkg::LIM_W-1:0]   r_lim;
    logic [sobel_pkg::THR_W:0]     thr_p1;
    logic [sobel_pkg::LIM_W-1:0]   thr_sq;
    logic [CNW-1:0] width_eff;
    logic [RNW-1:0] height_eff;
    logic cfg_we;

    logic grad_valid, grad_ready;
    sobel_pkg::t_grad grad;
    sobel_pkg::t_result res;

    // Configuration registers; the threshold is kept as its squared successor.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign thr_p1      = {1'b0, i_cfg_data[sobel_pkg::THR_W-1:0]} + (sobel_pkg::THR_W+1)'(1);
    assign thr_sq      = sobel_pkg::LIM_W'(thr_p1) * sobel_pkg::LIM_W'(thr_p1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= sobel_pkg::RST_IMG_W;
            r_img_h <= sobel_pkg::RST_IMG_H;
            r_lim   <= sobel_pkg::RST_LIM;
        end else if (cfg_we) begin
            case (i_cfg_index)
                sobel_pkg::CFG_IMAGE_WIDTH: begin
                    r_img_w <= i_cfg_data[sobel_pkg::IMG_W_W-1:0];
                end
                sobel_pkg::CFG_IMAGE_HEIGHT: begin
                    r_img_h <= i_cfg_data;
                end
                sobel_pkg::CFG_EDGE_THRESHOLD: begin
                    r_lim <= thr_sq;
                end
                default: begin
                end
            endcase
        end
    end

    // Effective geometry clamped to the supported range.
    always_comb begin
        if (r_img_w < sobel_pkg::IMG_W_W'(3)) begin
            width_eff = CNW'(3);
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            width_eff = CNW'(MAX_WIDTH);
        end else begin
            width_eff = CNW'(r_img_w);
        end
        if (r_img_h < sobel_pkg::IMG_H_W'(3)) begin
            height_eff = RNW'(3);
        end else if (32'(r_img_h) > 32'(MAX_HEIGHT)) begin
            height_eff = RNW'(MAX_HEIGHT);
        end else begin
            height_eff = RNW'(r_img_h);
        end
    end

    // Window front end: counters, line stores, window and gradients.
    sobel_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_width       (width_eff),
        .i_height      (height_eff),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_pixel       (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .o_valid       (grad_valid),
        .i_ready       (grad_ready),
        .o_grad        (grad)
    );

    // Magnitude back end: squares, threshold compare and result register.
    sobel_mag u_mag (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_limit  (r_lim),
        .i_valid  (grad_valid),
        .o_ready  (grad_ready),
        .i_grad   (grad),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (res)
    );

    assign m_axis_tdata = {sobel_pkg::OUT_PAD'(0), res.col, res.row, res.edge_value};
    assign m_axis_tlast = res.frame_end;

    // A gradient item that is not taken must stay unchanged.
    a_grad_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grad_valid && !grad_ready |=> grad_valid && $stable(grad))
        else $error("gradient item changed while stalled");

    // Results carry only the edge codes EDGE_ON and EDGE_OFF.
    a_edge_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] == sobel_pkg::EDGE_ON)
                       || (m_axis_tdata[7:0] == sobel_pkg::EDGE_OFF))
        else $error("edge value is neither 0 nor 255");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !grad_valid)
        else $error("pipeline holds an item after reset");

endmodule

`default_nettype wire
